// ----- hdl/wrm_pkg.sv -----
// Shared constants, command codes and control/status types of the rate meter.
`default_nettype none

package wrm_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int EVENT_W  = 16;
  localparam int TIME_W   = 48;
  localparam int WINDOW_W = 32;
  localparam int COUNT_W  = 32;
  localparam int RATE_W   = 49;

  // count scaled to fixed point, and the quotient width the divider must cover
  localparam int SCALED_W = COUNT_W + FRACTION_BITS;
  localparam int QUOT_W   = (SCALED_W > RATE_W) ? SCALED_W : RATE_W;
  localparam int PROD_W   = QUOT_W + WINDOW_W;
  localparam int MUL_SPLIT = 32;
  localparam int HI_W     = QUOT_W - MUL_SPLIT;
  localparam int STEP_W   = $clog2(QUOT_W);

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);
  localparam logic [RATE_W-1:0]   RATE_MAX     = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic apply;
    logic rate_eval;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic sum;
    logic load_out;
  } wrm_ctl_t;

  typedef struct packed {
    logic need_div;
    logic restart;
  } wrm_stat_t;

endpackage

`default_nettype wire

// ----- hdl/wrm_datapath.sv -----
// Datapath of the rate meter: window state, multiplier, serial divider, output register.
`default_nettype none

module wrm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [wrm_pkg::WINDOW_W-1:0]  cfg_data,
  input  wire logic [wrm_pkg::CMD_W-1:0]     command,
  input  wire logic [wrm_pkg::EVENT_W-1:0]   event_count,
  input  wire logic [wrm_pkg::TIME_W-1:0]    now_ticks,
  input  wire wrm_pkg::wrm_ctl_t             ctl,
  output wrm_pkg::wrm_stat_t                 stat,
  output logic [wrm_pkg::RATE_W-1:0]         rate_fixed
);
  import wrm_pkg::*;

  // configuration and window state
  logic [WINDOW_W-1:0] window_ticks;
  logic                window_valid;
  logic [TIME_W-1:0]   window_start;
  logic [COUNT_W-1:0]  window_count;
  logic [RATE_W-1:0]   previous_rate;

  // per-word working registers
  logic [CMD_W-1:0]    cmd_q;
  logic [EVENT_W-1:0]  cnt_q;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   delta_q;
  logic                restart_q;
  logic [SCALED_W-1:0] base_q;
  logic [QUOT_W-1:0]   mul_a_q;
  logic [WINDOW_W-1:0] mul_b_q;
  logic [PROD_W-1:0]   prod;
  logic [RATE_W-1:0]   result_q;

  logic [WINDOW_W-1:0]   w_eff;
  logic [WINDOW_W:0]     w_dbl;
  logic                  after_start;
  logic [TIME_W-1:0]     diff;
  logic                  restart;
  logic [COUNT_W:0]      count_add;
  logic [COUNT_W-1:0]    count_sat;

  logic                  ge1, ge2;
  logic [SCALED_W-1:0]   scaled;
  logic                  need_div;
  logic [SCALED_W-1:0]   base_sel;
  logic [QUOT_W-1:0]     quot_sel;
  logic [QUOT_W-1:0]     a_sel;
  logic [WINDOW_W-1:0]   b_sel;

  logic [2*MUL_SPLIT-1:0]      lo_prod;
  logic [HI_W+WINDOW_W-1:0]    hi_prod;
  logic [WINDOW_W:0]           div_t;
  logic                        div_ge;
  logic [WINDOW_W-1:0]         div_rem;
  logic [QUOT_W:0]             sum;
  logic [RATE_W-1:0]           sum_sat;

  // a zero window acts as a one-tick window
  assign w_eff = (window_ticks == '0) ? WINDOW_W'(1) : window_ticks;
  assign w_dbl = {w_eff, 1'b0};

  assign after_start = now_q >= window_start;
  assign diff        = now_q - window_start;
  assign restart     = (cmd_q == CMD_UPDATE) &&
                       (!window_valid || (after_start && diff >= TIME_W'(w_eff)));
  assign count_add   = {1'b0, window_count} + (COUNT_W+1)'(cnt_q);
  assign count_sat   = count_add[COUNT_W] ? COUNT_MAX : count_add[COUNT_W-1:0];

  // rate evaluation on the stored delta
  assign ge1    = delta_q >= TIME_W'(w_eff);
  assign ge2    = delta_q >= TIME_W'(w_dbl);
  assign scaled = {window_count, {FRACTION_BITS{1'b0}}};

  always_comb begin
    need_div = 1'b0;
    base_sel = '0;
    quot_sel = '0;
    a_sel    = '0;
    b_sel    = '0;
    if (!window_valid || ge2) begin
      need_div = 1'b0;
    end else if (ge1) begin
      // decay of the finished window's count
      need_div = 1'b1;
      a_sel    = QUOT_W'(scaled);
      b_sel    = WINDOW_W'(w_dbl - delta_q[WINDOW_W:0]);
    end else begin
      base_sel = scaled;
      if (delta_q == '0) begin
        quot_sel = QUOT_W'(previous_rate);
      end else begin
        need_div = 1'b1;
        a_sel    = QUOT_W'(previous_rate);
        b_sel    = w_eff - delta_q[WINDOW_W-1:0];
      end
    end
  end

  assign stat.need_div = need_div;
  assign stat.restart  = restart_q;

  // two partial products, then one quotient bit per clock in place
  assign lo_prod = (2*MUL_SPLIT)'(mul_a_q[MUL_SPLIT-1:0]) * (2*MUL_SPLIT)'(mul_b_q);
  assign hi_prod = (HI_W+WINDOW_W)'(mul_a_q[QUOT_W-1:MUL_SPLIT]) *
                   (HI_W+WINDOW_W)'(mul_b_q);

  assign div_t   = {prod[PROD_W-1:QUOT_W], prod[QUOT_W-1]};
  assign div_ge  = div_t >= {1'b0, w_eff};
  assign div_rem = div_ge ? WINDOW_W'(div_t - {1'b0, w_eff}) : div_t[WINDOW_W-1:0];

  assign sum     = (QUOT_W+1)'(base_q) + (QUOT_W+1)'(prod[QUOT_W-1:0]);
  assign sum_sat = (sum > (QUOT_W+1)'(RATE_MAX)) ? RATE_MAX : sum[RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks  <= WINDOW_RESET;
      window_valid  <= 1'b0;
      window_start  <= '0;
      window_count  <= '0;
      previous_rate <= '0;
      restart_q     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ticks <= cfg_data;
      end
      if (ctl.apply) begin
        restart_q <= restart;
        if (cmd_q == CMD_CLEAR) begin
          window_valid  <= 1'b0;
          window_start  <= '0;
          window_count  <= '0;
          previous_rate <= '0;
        end else if (cmd_q == CMD_UPDATE && !restart && after_start) begin
          window_count <= count_sat;
        end
      end
      if (ctl.sum && restart_q) begin
        previous_rate <= sum_sat;
        window_start  <= now_q;
        window_count  <= COUNT_W'(cnt_q);
        window_valid  <= 1'b1;
        restart_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q <= command;
      cnt_q <= event_count;
      now_q <= now_ticks;
    end
    if (ctl.apply) begin
      delta_q <= after_start ? diff : '0;
    end
    if (ctl.sum && restart_q) begin
      delta_q <= '0;
    end
    if (ctl.rate_eval) begin
      base_q  <= base_sel;
      mul_a_q <= a_sel;
      mul_b_q <= b_sel;
      prod    <= PROD_W'(quot_sel);
    end
    if (ctl.mul_lo) begin
      prod <= PROD_W'(lo_prod);
    end
    if (ctl.mul_hi) begin
      prod <= prod + PROD_W'({hi_prod, {MUL_SPLIT{1'b0}}});
    end
    if (ctl.div_step) begin
      prod <= {div_rem, prod[QUOT_W-2:0], div_ge};
    end
    if (ctl.sum) begin
      result_q <= sum_sat;
    end
    if (ctl.load_out) begin
      rate_fixed <= result_q;
    end
  end

  a_clear_drops_window: assert property (@(posedge clk) disable iff (rst)
    ctl.apply && (cmd_q == CMD_CLEAR) |=> !window_valid)
    else $error("clear left a window open");

  a_restart_commits: assert property (@(posedge clk) disable iff (rst)
    ctl.sum && restart_q |=> window_valid && (window_start == $past(now_q)) &&
                             (delta_q == '0) && !restart_q)
    else $error("window restart not committed");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    !ctl.load_out |=> $stable(rate_fixed))
    else $error("output word changed without a load");

endmodule

`default_nettype wire

// ----- hdl/wrm_controller.sv -----
// Sequencer of the rate meter: one-hot state machine, divide step count, output valid.
`default_nettype none

module wrm_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire wrm_pkg::wrm_stat_t    stat,
  output wrm_pkg::wrm_ctl_t          ctl
);
  import wrm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_APPLY  = 8'b0000_0010,
    ST_RATE   = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_SUM    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               out_valid_next;
  logic               last_step;
  logic               out_free;

  assign in_stall  = rst || (state != ST_IDLE);
  assign last_step = step == STEP_W'(QUOT_W - 1);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_RATE;
      ST_RATE:   state_next = stat.need_div ? ST_MUL_LO : ST_SUM;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_DIV;
      ST_DIV:    if (last_step) state_next = ST_SUM;
      ST_SUM:    state_next = stat.restart ? ST_RATE : ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load_in   = (state == ST_IDLE) && in_valid;
    ctl.apply     = state == ST_APPLY;
    ctl.rate_eval = state == ST_RATE;
    ctl.mul_lo    = state == ST_MUL_LO;
    ctl.mul_hi    = state == ST_MUL_HI;
    ctl.div_step  = state == ST_DIV;
    ctl.sum       = state == ST_SUM;
    ctl.load_out  = (state == ST_DONE) && out_free;
  end

  assign step_next = (state == ST_DIV) ? step + STEP_W'(1) : '0;

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_APPLY)
    else $error("accepted word did not start processing");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && last_step |=> state == ST_SUM)
    else $error("divide did not end after the last quotient bit");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result shown outside the done state");

endmodule

`default_nettype wire

// ----- hdl/windowed_event_rate_meter.sv -----
// Top level of the sliding-window event rate meter.
`default_nettype none

// Sliding-window rate meter. Each input word carries a command (update,
// query or clear; the unused code acts as a query), an event count and the
// current time in ticks; each word returns exactly one result word, the rate
// at that time in counts per window with FRACTION_BITS fraction bits,
// truncated and saturated at the full 49-bit range. One word is processed
// at a time. A word that needs a division passes the multiplier and the
// divider; an update that opens a new window then evaluates it again, and
// the meter returns to idle before taking the next word. Words that need
// no division (no window, two or more windows old, a window opened at that
// very time, or a clear) skip both. The radix-2 divider produces one
// quotient bit per clock over 49 bits, fed by a multiplier that forms its
// product from two partial products split at bit 32. The output register
// parts the channels: a new word is accepted while the previous result
// still waits. The user must write window_ticks through cfg_we and cfg_data
// only while idle (not enforced here). A value of zero acts as one tick.
module windowed_event_rate_meter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // window length register
  input  wire logic                          cfg_we,
  input  wire logic [wrm_pkg::WINDOW_W-1:0]  cfg_data,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wrm_pkg::CMD_W-1:0]     command,
  input  wire logic [wrm_pkg::EVENT_W-1:0]   event_count,
  input  wire logic [wrm_pkg::TIME_W-1:0]    now_ticks,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wrm_pkg::RATE_W-1:0]         rate_fixed
);
  import wrm_pkg::*;

  wrm_ctl_t  ctl;
  wrm_stat_t stat;

  // sequencing: accept, apply command, evaluate, multiply, divide, sum, show
  wrm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // window state and arithmetic
  wrm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .command     (command),
    .event_count (event_count),
    .now_ticks   (now_ticks),
    .ctl         (ctl),
    .stat        (stat),
    .rate_fixed  (rate_fixed)
  );

endmodule

`default_nettype wire
